FILE: design/baro_pressure_temp_compensation_core_defines.svh
// Assertion macros used by the compensation core top level.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_CORE_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BPTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BPTC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/bptc_pkg.sv
// Shared types and constants of the barometric compensation core.
package bptc_pkg;

	localparam int NUM_STAGES = 11;

	localparam logic [2:0] REG_SENS_COEFF    = 3'd0;
	localparam logic [2:0] REG_OFFSET_COEFF  = 3'd1;
	localparam logic [2:0] REG_SENS_TEMPCO   = 3'd2;
	localparam logic [2:0] REG_OFFSET_TEMPCO = 3'd3;
	localparam logic [2:0] REG_REF_TEMP      = 3'd4;
	localparam logic [2:0] REG_TEMP_SLOPE    = 3'd5;

	localparam logic signed [18:0] TEMP_REF  = 19'sd2000;
	localparam logic signed [18:0] TEMP_COLD = -19'sd1500;
	localparam logic signed [18:0] COLD_OFS  = TEMP_REF - TEMP_COLD;

	localparam logic [13:0] ALT_BASE_M = 14'd10351;
	localparam logic [28:0] ALT_SLOPE  = 29'd439804651;

	localparam int TEMP_SHIFT = 23;
	localparam int PROD_SHIFT = 21;
	localparam int PRES_SHIFT = 15;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} pipe_ctrl_t;

endpackage

FILE: design/bptc_pipe_ctrl.sv
// Valid and stage-enable chain of the compensation pipeline, with bubble collapse.
module bptc_pipe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_ready,
	output bptc_pkg::pipe_ctrl_t ctl
);

	localparam int Last = bptc_pkg::NUM_STAGES - 1;

	logic [bptc_pkg::NUM_STAGES-1:0] vld_q;
	logic [bptc_pkg::NUM_STAGES-1:0] en;

	always_comb begin
		en[Last] = !vld_q[Last] || out_ready;
		for (int k = Last - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k <= Last; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;

endmodule

FILE: design/baro_pressure_temp_compensation_core.sv
// Top level of the second-order barometric pressure and temperature compensation core.
// Throughput: one word per cycle; the pipeline stalls only while the output is held.
// Reset clears all stage valid bits and the six calibration registers to zero.
`include "baro_pressure_temp_compensation_core_defines.svh"

module baro_pressure_temp_compensation_core #(
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // raw_temperature[23:0], raw_pressure[47:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata    // temperature_centi[18:0], pressure_pa[50:19],
	                               // altitude_fixed[82:51], zero[87:83]
);

	localparam int AltHi = 63 - FRACTION_BITS;
	localparam int AltLo = 32 - FRACTION_BITS;
	localparam logic [31:0] AltBase = 32'(64'(bptc_pkg::ALT_BASE_M) << FRACTION_BITS);

	bptc_pkg::pipe_ctrl_t ctl;

	logic [15:0] cal_sens_coeff_q, cal_offset_coeff_q, cal_sens_tempco_q;
	logic [15:0] cal_offset_tempco_q, cal_ref_temp_q, cal_temp_slope_q;

	logic signed [24:0] dt_s1;
	logic        [23:0] d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;
	logic signed [41:0] p6_s2, p4_s2, p3_s2;
	logic signed [18:0] d_c, temp_c, e_c;
	logic signed [35:0] off1_c, sens1_c;
	logic signed [18:0] temp_s3, temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;
	logic signed [18:0] temp_s9, temp_s10, temp_s11;
	logic signed [18:0] d_s3, e_s3;
	logic               lt_s3, neg_s3, lt_s4, neg_s4, lt_s5;
	logic signed [35:0] off1_s3, sens1_s3, off1_s4, sens1_s4, off1_s5, sens1_s5;
	logic signed [37:0] dsq_c, esq_c;
	logic        [35:0] dd_s4, ee_s4;
	logic        [38:0] dd5_c, ee7_c, ee11_c, off2_c, sens2_c;
	logic        [38:0] off2_s5, sens2_s5;
	logic signed [39:0] off_s6, sens_s6, off_s7, off_s8;
	logic        [43:0] pl_s7;
	logic signed [44:0] ph_s7;
	logic signed [64:0] x_s8, xs_c;
	logic signed [47:0] q_c;
	logic        [31:0] pres_s9, pres_s10, pres_s11;
	logic signed [61:0] prod_s10;
	logic        [31:0] alt_s11;

	bptc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.ctl       (ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_sens_coeff_q    <= '0;
			cal_offset_coeff_q  <= '0;
			cal_sens_tempco_q   <= '0;
			cal_offset_tempco_q <= '0;
			cal_ref_temp_q      <= '0;
			cal_temp_slope_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				bptc_pkg::REG_SENS_COEFF:    cal_sens_coeff_q    <= cfg_wdata;
				bptc_pkg::REG_OFFSET_COEFF:  cal_offset_coeff_q  <= cfg_wdata;
				bptc_pkg::REG_SENS_TEMPCO:   cal_sens_tempco_q   <= cfg_wdata;
				bptc_pkg::REG_OFFSET_TEMPCO: cal_offset_tempco_q <= cfg_wdata;
				bptc_pkg::REG_REF_TEMP:      cal_ref_temp_q      <= cfg_wdata;
				bptc_pkg::REG_TEMP_SLOPE:    cal_temp_slope_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign d_c     = $signed(p6_s2[41:bptc_pkg::TEMP_SHIFT]);
	assign temp_c  = d_c + bptc_pkg::TEMP_REF;
	assign e_c     = d_c + bptc_pkg::COLD_OFS;
	assign off1_c  = $signed({4'b0, cal_offset_coeff_q, 16'b0}) + $signed(p4_s2[41:7]);
	assign sens1_c = $signed({5'b0, cal_sens_coeff_q, 15'b0}) + $signed(p3_s2[41:8]);

	assign dsq_c = d_s3 * d_s3;
	assign esq_c = e_s3 * e_s3;

	assign dd5_c   = {1'b0, dd_s4, 2'b0} + 39'(dd_s4);
	assign ee7_c   = {ee_s4, 3'b0} - 39'(ee_s4);
	assign ee11_c  = {ee_s4, 3'b0} + 39'({ee_s4, 1'b0}) + 39'(ee_s4);
	assign off2_c  = (dd5_c >> 1) + (neg_s4 ? ee7_c : 39'd0);
	assign sens2_c = (dd5_c >> 2) + (neg_s4 ? (ee11_c >> 1) : 39'd0);

	assign xs_c = x_s8 >>> bptc_pkg::PROD_SHIFT;
	assign q_c  = $signed(xs_c[47:0]) - off_s8;

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			dt_s1 <= $signed({1'b0, s_tdata[23:0]}) - $signed({1'b0, cal_ref_temp_q, 8'b0});
			d1_s1 <= s_tdata[47:24];
		end
		if (ctl.en[1]) begin
			p6_s2 <= dt_s1 * $signed({1'b0, cal_temp_slope_q});
			p4_s2 <= dt_s1 * $signed({1'b0, cal_offset_tempco_q});
			p3_s2 <= dt_s1 * $signed({1'b0, cal_sens_tempco_q});
			d1_s2 <= d1_s1;
		end
		if (ctl.en[2]) begin
			temp_s3  <= temp_c;
			d_s3     <= d_c;
			e_s3     <= e_c;
			lt_s3    <= d_c[18];
			neg_s3   <= e_c[18];
			off1_s3  <= off1_c;
			sens1_s3 <= sens1_c;
			d1_s3    <= d1_s2;
		end
		if (ctl.en[3]) begin
			dd_s4    <= dsq_c[35:0];
			ee_s4    <= esq_c[35:0];
			lt_s4    <= lt_s3;
			neg_s4   <= neg_s3;
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
			temp_s4  <= temp_s3;
			d1_s4    <= d1_s3;
		end
		if (ctl.en[4]) begin
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
			lt_s5    <= lt_s4;
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			temp_s5  <= temp_s4;
			d1_s5    <= d1_s4;
		end
		if (ctl.en[5]) begin
			off_s6  <= off1_s5 - $signed({1'b0, (lt_s5 ? off2_s5 : 39'd0)});
			sens_s6 <= sens1_s5 - $signed({1'b0, (lt_s5 ? sens2_s5 : 39'd0)});
			temp_s6 <= temp_s5;
			d1_s6   <= d1_s5;
		end
		if (ctl.en[6]) begin
			pl_s7   <= d1_s6 * sens_s6[19:0];
			ph_s7   <= $signed({1'b0, d1_s6}) * $signed(sens_s6[39:20]);
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
		end
		if (ctl.en[7]) begin
			x_s8    <= $signed({ph_s7, 20'b0}) + $signed({21'b0, pl_s7});
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
		if (ctl.en[8]) begin
			pres_s9 <= q_c[bptc_pkg::PRES_SHIFT+31:bptc_pkg::PRES_SHIFT];
			temp_s9 <= temp_s8;
		end
		if (ctl.en[9]) begin
			prod_s10 <= $signed(pres_s9) * $signed({1'b0, bptc_pkg::ALT_SLOPE});
			pres_s10 <= pres_s9;
			temp_s10 <= temp_s9;
		end
		if (ctl.en[10]) begin
			alt_s11  <= AltBase - prod_s10[AltHi:AltLo];
			pres_s11 <= pres_s10;
			temp_s11 <= temp_s10;
		end
	end

	assign s_tready = ctl.en[0];
	assign m_tvalid = ctl.vld[bptc_pkg::NUM_STAGES-1];
	assign m_tdata  = {5'b0, alt_s11, pres_s11, temp_s11};

	`BPTC_ASSERT_IMP(a_ready_when_drained, m_tready, s_tready,
		"input stalled while output is free")
	`BPTC_ASSERT_IMP(a_cold_below_ref, ctl.vld[2] && neg_s3, lt_s3,
		"cold correction flagged above reference temperature")
	`BPTC_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, ctl.vld[0],
		"accepted word did not enter the first stage")

endmodule

FILE: bench/baro_pressure_temp_compensation_core_test.sv
// Self-checking testbench for the second-order barometric compensation core.
`timescale 1ns / 100ps

module baro_pressure_temp_compensation_core_test;

	localparam int FRACTION_BITS = 16;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int DRAIN_LIMIT = 20000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS = 300;

	typedef struct packed {
		logic [31:0] altitude_fixed;
		logic [31:0] pressure_pa;
		logic [18:0] temperature_centi;
	} reading_t;

	class comp_scoreboard;
		logic [15:0] cal [6];
		reading_t readings_due [$];
		int fail_count;

		function new();
			foreach (cal[i]) cal[i] = '0;
			fail_count = 0;
		endfunction

		function void write_cal(input logic [2:0] idx, input logic [15:0] value);
			if (idx <= bptc_pkg::REG_TEMP_SLOPE)
				cal[idx] = value;
		endfunction

		function reading_t compensate(input logic [23:0] raw_temp, input logic [23:0] raw_pres);
			longint d1, d2, c1, c2, c3, c4, c5, c6;
			longint dt, temp, off, sens, d, sq, off2, sens2, e, sq2, p64, pres, prod;
			logic [31:0] alt;
			reading_t r;
			d2 = raw_temp;
			d1 = raw_pres;
			c1 = cal[bptc_pkg::REG_SENS_COEFF];
			c2 = cal[bptc_pkg::REG_OFFSET_COEFF];
			c3 = cal[bptc_pkg::REG_SENS_TEMPCO];
			c4 = cal[bptc_pkg::REG_OFFSET_TEMPCO];
			c5 = cal[bptc_pkg::REG_REF_TEMP];
			c6 = cal[bptc_pkg::REG_TEMP_SLOPE];
			dt = d2 - c5 * 256;
			temp = 2000 + ((dt * c6) >>> 23);
			off = c2 * 65536 + ((dt * c4) >>> 7);
			sens = c1 * 32768 + ((dt * c3) >>> 8);
			if (temp < 2000) begin
				d = temp - 2000;
				sq = 5 * d * d;
				off2 = sq >>> 1;
				sens2 = sq >>> 2;
				if (temp < -1500) begin
					e = temp + 1500;
					sq2 = e * e;
					off2 += 7 * sq2;
					sens2 += (11 * sq2) >>> 1;
				end
				off -= off2;
				sens -= sens2;
			end
			p64 = (((d1 * sens) >>> 21) - off) >>> 15;
			pres = int'(p64);
			prod = (pres * 64'sd439804651) >>> (32 - FRACTION_BITS);
			alt = (32'(10351) << FRACTION_BITS) - prod[31:0];
			r.temperature_centi = temp[18:0];
			r.pressure_pa = pres[31:0];
			r.altitude_fixed = alt;
			return r;
		endfunction

		function void note_input(input logic [47:0] word);
			readings_due.push_back(compensate(word[23:0], word[47:24]));
		endfunction

		function void check_result(input logic [87:0] word);
			reading_t want, got;
			got.temperature_centi = word[18:0];
			got.pressure_pa = word[50:19];
			got.altitude_fixed = word[82:51];
			if (readings_due.size() == 0) begin
				$error("result word with no input pending");
				fail_count++;
				return;
			end
			want = readings_due.pop_front();
			if (got.temperature_centi !== want.temperature_centi) begin
				$error("temperature_centi: expected %0d, got %0d",
					$signed(want.temperature_centi), $signed(got.temperature_centi));
				fail_count++;
			end
			if (got.pressure_pa !== want.pressure_pa) begin
				$error("pressure_pa: expected %0d, got %0d",
					$signed(want.pressure_pa), $signed(got.pressure_pa));
				fail_count++;
			end
			if (got.altitude_fixed !== want.altitude_fixed) begin
				$error("altitude_fixed: expected %0d, got %0d",
					$signed(want.altitude_fixed), $signed(got.altitude_fixed));
				fail_count++;
			end
		endfunction

		function int pending();
			return readings_due.size();
		endfunction

		function void flush_missing();
			$error("%0d result words never arrived", readings_due.size());
			fail_count++;
			readings_due.delete();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // raw_temperature[23:0], raw_pressure[47:24]
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;   // temperature_centi[18:0], pressure_pa[50:19],
	                        // altitude_fixed[82:51], zero[87:83]

	logic steady;
	logic [15:0] cal_plan [6];
	logic [15:0] typical_cal [6] = '{16'd40127, 16'd36924, 16'd23317,
		16'd23282, 16'd33464, 16'd28312};
	comp_scoreboard sb;

	baro_pressure_temp_compensation_core #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 37);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	task automatic send_word(input logic [23:0] raw_temp, input logic [23:0] raw_pres);
		while (!steady && $urandom_range(99) < 37) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {raw_pres, raw_temp};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (sb.pending() != 0)
			sb.flush_missing();
		repeat (bptc_pkg::NUM_STAGES + 4) @(negedge clk);
	endtask

	task automatic load_cal();
		logic [15:0] spare_data;
		for (int i = bptc_pkg::REG_SENS_COEFF; i <= bptc_pkg::REG_TEMP_SLOPE; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= 3'(i);
			cfg_wdata <= cal_plan[i];
			sb.write_cal(3'(i), cal_plan[i]);
			@(negedge clk);
		end
		// spare indexes must leave every register alone
		for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
			spare_data = 16'($urandom);
			cfg_addr <= 3'(i);
			cfg_wdata <= spare_data;
			sb.write_cal(3'(i), spare_data);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [23:0] pick_raw_temp();
		longint centre, v;
		if ($urandom_range(9) < 2)
			return 24'($urandom);
		centre = longint'(cal_plan[bptc_pkg::REG_REF_TEMP]) * 256;
		v = centre + longint'($urandom_range(1 << 22)) - (1 << 21);
		if (v < 0)
			v = 0;
		if (v > 24'hFFFFFF)
			v = 24'hFFFFFF;
		return v[23:0];
	endfunction

	initial begin
		#2000000;
		$display("baro_pressure_temp_compensation_core_test NOT OK");
		$finish;
	end

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		steady = 1'b0;
		foreach (cal_plan[i]) cal_plan[i] = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset calibration
		send_word(24'd0, 24'd0);
		send_word(24'hFFFFFF, 24'hFFFFFF);
		drain();

		// typical calibration, both cold thresholds
		foreach (cal_plan[i]) cal_plan[i] = typical_cal[i];
		load_cal();
		send_word(24'd8569150, 24'd9085466);
		send_word(24'd8566784, 24'd9085466);
		send_word(24'd8566783, 24'd9085466);
		send_word(24'd7529764, 24'd9085466);
		send_word(24'd7529763, 24'd9085466);
		send_word(24'd0, 24'hFFFFFF);
		send_word(24'hFFFFFF, 24'd0);
		send_word(24'hAAAAAA, 24'h555555);
		send_word(24'h555555, 24'hAAAAAA);
		drain();

		foreach (cal_plan[i]) cal_plan[i] = 16'hFFFF;
		load_cal();
		send_word(24'd0, 24'd0);
		send_word(24'd0, 24'hFFFFFF);
		send_word(24'hFFFFFF, 24'hFFFFFF);
		send_word(24'hFFFFFF, 24'd0);
		send_word(24'h800000, 24'h7FFFFF);
		drain();

		// deepest cold: largest second-order terms
		cal_plan[bptc_pkg::REG_SENS_COEFF] = 16'h0000;
		cal_plan[bptc_pkg::REG_OFFSET_COEFF] = 16'hFFFF;
		cal_plan[bptc_pkg::REG_SENS_TEMPCO] = 16'hFFFF;
		cal_plan[bptc_pkg::REG_OFFSET_TEMPCO] = 16'h0000;
		cal_plan[bptc_pkg::REG_REF_TEMP] = 16'hFFFF;
		cal_plan[bptc_pkg::REG_TEMP_SLOPE] = 16'hFFFF;
		load_cal();
		send_word(24'd0, 24'hFFFFFF);
		send_word(24'd0, 24'd1);
		send_word(24'h123456, 24'h800000);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			foreach (cal_plan[i]) begin
				case (ph)
					1, 4: cal_plan[i] = 16'($urandom);
					5: cal_plan[i] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
					default: cal_plan[i] = typical_cal[i] + 16'($urandom_range(8191)) - 16'd4096;
				endcase
			end
			load_cal();
			steady = (ph == 3);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (ph == 2 && n == PHASE_WORDS / 2)
					drain();
				send_word(pick_raw_temp(), 24'($urandom));
			end
			drain();
			steady = 1'b0;
		end

		if (sb.fail_count == 0)
			$display("baro_pressure_temp_compensation_core_test OK");
		else
			$display("baro_pressure_temp_compensation_core_test NOT OK");
		$finish;
	end

endmodule
